@@ rtl/eaq_pkg.sv @@
// ----------------------------------------------------------------------------
// eaq_pkg
// Shared types, constants and the arctangent table for the euler to
// quaternion converter.
// ----------------------------------------------------------------------------
package eaq_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 14;
  localparam int ATAN_ENTRIES     = 24;
  localparam int CW               = 34;   // cordic datapath width, q2.30 plus growth

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  // pi/180 * 2^23, needs 19 bits as a signed value
  localparam logic signed [18:0]   DEG_TO_RAD  = 19'sd146409;

  localparam logic signed [17:0] FULL_WRAP    = 18'sd46080;
  localparam logic signed [17:0] HALF_WRAP    = 18'sd23040;
  localparam logic signed [17:0] QUARTER_HALF = 18'sd11520;

  typedef logic signed [CW-1:0] cw_t;

  function automatic cw_t atan_q30(input int idx);
    cw_t r;
    r = '0;
    unique case (idx)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/eaq_sincos.sv @@
// ----------------------------------------------------------------------------
// eaq_sincos
// Pipelined half-angle sine/cosine: wrap and fold, scale to radians, then one
// cordic rotation per stage. Output in q2.30, sign folding applied.
// ----------------------------------------------------------------------------
module eaq_sincos #(
  parameter int CORDIC_STEPS = eaq_pkg::CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [15:0]      ang,
  output eaq_pkg::cw_t            sin_o,
  output eaq_pkg::cw_t            cos_o
);
  import eaq_pkg::*;

  localparam int NS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  logic signed [17:0] h_w, h_f;
  logic               neg_w;
  logic signed [17:0] h_r;
  logic               neg0_r;

  always_comb begin
    h_w = 18'(ang);
    if (h_w > HALF_WRAP) begin
      h_w = h_w - FULL_WRAP;
    end else if (h_w < -HALF_WRAP) begin
      h_w = h_w + FULL_WRAP;
    end
    neg_w = 1'b0;
    h_f   = h_w;
    if (h_w > QUARTER_HALF) begin
      h_f   = h_w - HALF_WRAP;
      neg_w = 1'b1;
    end else if (h_w < -QUARTER_HALF) begin
      h_f   = h_w + HALF_WRAP;
      neg_w = 1'b1;
    end
  end

  // stage 0: folded angle; stage 1: radians
  cw_t z1_r;
  logic neg1_r;
  logic signed [35:0] zprod;
  assign zprod = 36'(h_r) * 36'(DEG_TO_RAD);

  always_ff @(posedge clk) begin
    if (en) begin
      h_r    <= h_f;
      neg0_r <= neg_w;
      z1_r   <= CW'(zprod);
      neg1_r <= neg0_r;
    end
  end

  cw_t  x_r [NS+1];
  cw_t  y_r [NS+1];
  cw_t  z_r [NS+1];
  logic n_r [NS+1];

  always_comb begin
    x_r[0] = CORDIC_GAIN;
    y_r[0] = '0;
    z_r[0] = z1_r;
    n_r[0] = neg1_r;
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    cw_t xs, ys, xn, yn, zn;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_comb begin
      if (!z_r[i][CW-1]) begin
        xn = x_r[i] - ys;
        yn = y_r[i] + xs;
        zn = z_r[i] - atan_q30(i);
      end else begin
        xn = x_r[i] + ys;
        yn = y_r[i] - xs;
        zn = z_r[i] + atan_q30(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= xn;
        y_r[i+1] <= yn;
        z_r[i+1] <= zn;
        n_r[i+1] <= n_r[i];
      end
    end
  end

  assign cos_o = n_r[NS] ? -x_r[NS] : x_r[NS];
  assign sin_o = n_r[NS] ? -y_r[NS] : y_r[NS];

endmodule

@@ rtl/euler_angles_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion
// Yaw/pitch/roll in 1/64 degree to a unit quaternion (zyx order), signed
// fixed point, through three pipelined half-angle cordic units.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit first)
//  in_     | in  | yaw_deg[15:0], pitch_deg[31:16], roll_deg[47:32]
//  out_    | out | quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
//
//  one word accepted per cycle while the pipe is not stalled; the pipe has
//  2 angle stages, one stage per cordic rotation and 4 product/round stages.
//  the whole pipe advances when the output register is empty or being taken;
//  in_tready follows that, so a stall holds every stage in place.
//  rst_n (synchronous) clears the valid bits only.
module euler_angles_to_quaternion #(
  parameter int CORDIC_STEPS = eaq_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = eaq_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // yaw_deg, pitch_deg, roll_deg
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // quat_w, quat_x, quat_y, quat_z
);
  import eaq_pkg::*;

  localparam int NS  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int LAT = NS + 2;
  localparam int SH  = 30 - FRAC_BITS;
  localparam logic signed [CW+1:0] LIM = (CW+2)'(1) <<< FRAC_BITS;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic [LAT+3:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT+2:0], in_tvalid};
    end
  end
  assign out_tvalid = vld_r[LAT+3];

  cw_t sy, cy, sp, cp, sr, cr;
  eaq_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(en), .ang(in_tdata[15:0]),  .sin_o(sy), .cos_o(cy));
  eaq_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(en), .ang(in_tdata[31:16]), .sin_o(sp), .cos_o(cp));
  eaq_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(en), .ang(in_tdata[47:32]), .sin_o(sr), .cos_o(cr));

  function automatic cw_t mul30(input cw_t a, input cw_t b);
    logic signed [2*CW-1:0] p;
    p = (2*CW)'(a) * (2*CW)'(b) + (2*CW)'(64'sd1 <<< 29);
    return CW'(p >>> 30);
  endfunction

  // stage a: pair products, yaw delayed
  cw_t crcp_r, srsp_r, crsp_r, srcp_r, sy_r, cy_r;
  // stage b: triple products
  cw_t p0_r, p1_r, p2_r, p3_r, p4_r, p5_r, p6_r, p7_r;
  // stage c: sums
  logic signed [CW+1:0] s_r [4];
  logic [15:0] q_r [4];

  logic [15:0] q_nxt [4];
  always_comb begin
    logic signed [CW+1:0] v;
    for (int k = 0; k < 4; k++) begin
      v = (s_r[k] + ((CW+2)'(1) <<< (SH-1))) >>> SH;
      if (v > LIM) v = LIM;
      if (v < -LIM) v = -LIM;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      q_nxt[k] = v[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      crcp_r <= mul30(cr, cp);
      srsp_r <= mul30(sr, sp);
      crsp_r <= mul30(cr, sp);
      srcp_r <= mul30(sr, cp);
      sy_r   <= sy;
      cy_r   <= cy;
      p0_r <= mul30(crcp_r, cy_r);
      p1_r <= mul30(srsp_r, sy_r);
      p2_r <= mul30(srcp_r, cy_r);
      p3_r <= mul30(crsp_r, sy_r);
      p4_r <= mul30(crsp_r, cy_r);
      p5_r <= mul30(srcp_r, sy_r);
      p6_r <= mul30(crcp_r, sy_r);
      p7_r <= mul30(srsp_r, cy_r);
      s_r[0] <= (CW+2)'(p0_r) + (CW+2)'(p1_r);
      s_r[1] <= (CW+2)'(p2_r) - (CW+2)'(p3_r);
      s_r[2] <= (CW+2)'(p4_r) + (CW+2)'(p5_r);
      s_r[3] <= (CW+2)'(p6_r) - (CW+2)'(p7_r);
      q_r <= q_nxt;
    end
  end

  assign out_tdata = {q_r[3], q_r[2], q_r[1], q_r[0]};

endmodule

@@ tb/sv/euler_angles_to_quaternion_test.sv @@
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion_test
// Streams yaw/pitch/roll words into the converter with random gaps and output
// stalls, predicts each quaternion with an independent half-angle cordic model
// and compares every result word field by field, in order.
// ----------------------------------------------------------------------------
module euler_angles_to_quaternion_test;
  import eaq_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int FRAC  = FRAC_BITS_DEF;
  localparam int N_RANDOM = 1400;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  class quat_scoreboard;
    quat_t pending[$];
    int mismatches;
    int checked;

    function longint rnd_shift(longint v, int n);
      if (n == 0) return v;
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint mul_q30(longint a, longint b);
      return rnd_shift(a * b, 30);
    endfunction

    // sine and cosine of half the angle, q2.30
    function void half_trig(logic signed [15:0] ang, output longint s, output longint c);
      longint h, x, y, z, nx;
      bit flip;
      h = ang;
      flip = 0;
      if (h > HALF_WRAP) h -= FULL_WRAP;
      else if (h < -HALF_WRAP) h += FULL_WRAP;
      if (h > QUARTER_HALF) begin
        h -= HALF_WRAP; flip = 1;
      end else if (h < -QUARTER_HALF) begin
        h += HALF_WRAP; flip = 1;
      end
      z = h * longint'(DEG_TO_RAD);
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= atan_q30(i);
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += atan_q30(i);
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function logic signed [15:0] to_q14(longint v);
      longint lim;
      lim = longint'(1) << FRAC;
      v = rnd_shift(v, 30 - FRAC);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void note_angles(angles_t a);
      longint sy, cy, sp, cp, sr, cr, crcp, srsp, crsp, srcp;
      quat_t q;
      half_trig(a.yaw, sy, cy);
      half_trig(a.pitch, sp, cp);
      half_trig(a.roll, sr, cr);
      crcp = mul_q30(cr, cp);
      srsp = mul_q30(sr, sp);
      crsp = mul_q30(cr, sp);
      srcp = mul_q30(sr, cp);
      q.w = to_q14(mul_q30(crcp, cy) + mul_q30(srsp, sy));
      q.x = to_q14(mul_q30(srcp, cy) - mul_q30(crsp, sy));
      q.y = to_q14(mul_q30(crsp, cy) + mul_q30(srcp, sy));
      q.z = to_q14(mul_q30(crcp, sy) - mul_q30(srsp, cy));
      pending.push_back(q);
    endfunction

    function void check_quat(quat_t got);
      quat_t exp_q;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp_q = pending.pop_front();
      checked++;
      if (got != exp_q) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: w %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d (exp/got)",
                   checked, exp_q.w, got.w, exp_q.x, got.x, exp_q.y, got.y,
                   exp_q.z, got.z);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [63:0] out_tdata;

  quat_scoreboard board = new();
  bit sending_done = 0;
  bit stall_free = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  euler_angles_to_quaternion dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_angles(in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_quat(out_tdata);
  end

  // receiver: random stall before each word, sometimes none at all
  initial begin
    int gap;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      gap = stall_free ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_angles(angles_t a, int gap);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= a;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'(23040 + $urandom_range(0, 4) - 2);
      2: return 16'(-23040 + $urandom_range(0, 4) - 2);
      3: return 16'(11520 * ($urandom_range(0, 6) - 3) + $urandom_range(0, 4) - 2);
      default: return 16'($urandom_range(0, 46080) - 23040);
    endcase
  endfunction

  initial begin
    logic [15:0] edges[12] = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'd23040,
                               -16'd23040, 16'd23041, -16'd23041, 16'd11520,
                               16'd11521, -16'd11521, 16'd5760};
    angles_t a;
    int fast;
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    for (int i = 0; i < 12; i++) begin
      a.yaw = edges[i];
      a.pitch = edges[(i + 4) % 12];
      a.roll = edges[(i + 8) % 12];
      send_angles(a, $urandom_range(0, 2));
    end
    for (int i = 0; i < 12; i++) begin
      a = '0;
      a.pitch = edges[i];
      send_angles(a, 0);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        // drain the pipe completely once
        in_tvalid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        stall_free = 1;
      end
      if (i == N_RANDOM / 2 + 200) stall_free = 0;
      fast = (i % 300) < 100;
      a.yaw = pick_angle();
      a.pitch = pick_angle();
      a.roll = pick_angle();
      send_angles(a, fast ? 0 : $urandom_range(0, 11));
    end
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (STEPS + 20) @(negedge clk);
    $display("converted %0d angle words, including wrap, fold and extreme angles,",
             board.checked);
    $display("with random input gaps and output stalls on both sides");
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
